// ----- rtl/lrgd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_pkg
// Shared types, widths and saturation helpers of the regression trainer.
// ----------------------------------------------------------------------------
package lrgd_pkg;

	localparam int DATA_W           = 32;
	localparam int ACC_W            = 64;
	localparam int FC_W             = 7;
	localparam int LR_W             = 16;
	localparam int FRAC_BITS        = 16;
	localparam int MAX_FEATURES_DEF = 64;
	localparam int COUNT_BITS_DEF   = 16;
	localparam logic [FC_W-1:0] FC_RESET = 7'd1;
	localparam logic [LR_W-1:0] LR_RESET = 16'd655;
	localparam logic REG_FEATURE_COUNT = 1'b0;
	localparam logic REG_LEARNING_RATE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [DATA_W-1:0] feature;
		logic [DATA_W-1:0] target;
		logic              batch_end;
		logic              last;
	} lrgd_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] prediction;
		logic [DATA_W-1:0] batch_loss;
		logic              loss_valid;
		logic              weights_updated;
	} lrgd_result_t;

	function automatic logic [DATA_W-1:0] sat32(input logic signed [ACC_W:0] v);
		if (v > 65'sd2147483647)
			return 32'h7fffffff;
		else if (v < -65'sd2147483648)
			return 32'h80000000;
		else
			return v[DATA_W-1:0];
	endfunction

	function automatic logic [ACC_W-1:0] sat64(input logic signed [ACC_W:0] v);
		if (v[ACC_W] != v[ACC_W-1])
			return v[ACC_W] ? 64'h8000000000000000 : 64'h7fffffffffffffff;
		else
			return v[ACC_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ----- rtl/lrgd_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module lrgd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire                                  clk,
	input  wire                                  we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                     wdata,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ----- rtl/lrgd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_div
// Restoring divider, 64-bit unsigned dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lrgd_div #(
	parameter int DVW = 17
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire  [lrgd_pkg::ACC_W-1:0]   dividend,
	input  wire  [DVW-1:0]               divisor,
	output logic                         done,
	output logic [lrgd_pkg::ACC_W-1:0]   quotient
);

	localparam int CW = $clog2(lrgd_pkg::ACC_W + 1);

	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] div_q;
	logic [CW-1:0]  cnt_q;
	logic           busy_q;
	logic [DVW:0]   trial;
	logic           take;

	assign trial = {rem_q, quotient[lrgd_pkg::ACC_W-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q   <= 1'b1;
				cnt_q    <= '0;
				rem_q    <= '0;
				div_q    <= divisor;
				quotient <= dividend;
			end else if (busy_q) begin
				rem_q    <= take ? DVW'(trial - {1'b0, div_q}) : DVW'(trial);
				quotient <= {quotient[lrgd_pkg::ACC_W-2:0], take};
				cnt_q    <= cnt_q + CW'(1);
				if (cnt_q == CW'(lrgd_pkg::ACC_W - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lrgd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_front
// Input acceptance, feature position tracking and a two-entry request queue.
// ----------------------------------------------------------------------------
module lrgd_front #(
	parameter int MAX_FEATURES = lrgd_pkg::MAX_FEATURES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          s_tvalid,
	output logic                         s_tready,
	input  wire  [63:0]                  s_tdata,
	input  wire                          s_tlast,
	input  wire                          s_tuser,
	input  wire  [$clog2(MAX_FEATURES+1)-1:0] n_eff,
	output logic                         q_valid,
	output lrgd_pkg::lrgd_item_t         q_item,
	output logic [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] q_idx,
	input  wire                          q_pop
);

	localparam int IW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
	localparam int NW = $clog2(MAX_FEATURES + 1);

	lrgd_pkg::lrgd_item_t ent_q [2];
	logic [IW-1:0]        eidx_q [2];
	logic                 wp_q, rp_q;
	logic [1:0]           cnt_q;
	logic [IW-1:0]        fi_q;
	logic                 push, last;

	assign s_tready = cnt_q != 2'd2;
	assign push     = s_tvalid && s_tready;
	assign last     = (NW'(fi_q) + NW'(1)) >= n_eff;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = ent_q[rp_q];
	assign q_idx    = eidx_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
			fi_q  <= '0;
		end else begin
			if (push) begin
				ent_q[wp_q]  <= '{func: s_tuser, feature: s_tdata[31:0],
					target: s_tdata[63:32], batch_end: s_tlast, last: last};
				eidx_q[wp_q] <= fi_q;
				wp_q         <= ~wp_q;
				fi_q         <= last ? '0 : fi_q + IW'(1);
			end
			if (q_pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(q_pop);
		end
	end

endmodule
`default_nettype wire

// ----- rtl/lrgd_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lrgd_back
// Sequencer: dot product, loss, gradient sweep, batch divide and weight update.
// ----------------------------------------------------------------------------
module lrgd_back #(
	parameter int MAX_FEATURES = lrgd_pkg::MAX_FEATURES_DEF,
	parameter int COUNT_BITS   = lrgd_pkg::COUNT_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          q_valid,
	input  lrgd_pkg::lrgd_item_t         q_item,
	input  wire  [(MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1)-1:0] q_idx,
	output logic                         q_pop,
	input  wire  [$clog2(MAX_FEATURES+1)-1:0] n_eff,
	input  wire  [lrgd_pkg::LR_W-1:0]    rate,
	output logic                         out_valid,
	input  wire                          out_ready,
	output lrgd_pkg::lrgd_result_t       out_res
);

	localparam int IW  = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
	localparam int NW  = $clog2(MAX_FEATURES + 1);
	localparam int DVW = COUNT_BITS + 1;
	localparam int AW  = lrgd_pkg::ACC_W;

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_DOT, S_ERR, S_SQ, S_LOSS, S_GRD_MUL, S_GRD_ADD,
		S_END, S_LDIV, S_UPD_RD, S_UPD_DIV, S_UPD_MUL, S_UPD_WR, S_CLR, S_OUT
	} state_t;

	state_t                   state_q;
	lrgd_pkg::lrgd_item_t     it_q;
	logic [IW-1:0]            idx_q, j_q, rd_addr;
	logic signed [AW-1:0]     dot_q, prod_s1, gcur_q;
	logic [AW-1:0]            loss_q;
	logic [COUNT_BITS-1:0]    cnt_q;
	logic [31:0]              err_q, pred_q, wcur_q, mean_q, loss_out_q;
	logic                     neg_q, upd_q;
	logic [MAX_FEATURES-1:0]  wvalid_q, gvalid_q;
	logic                     wv_s1, gv_s1;

	logic [31:0]              w_rdata, s_rdata;
	logic [AW-1:0]            g_rdata;
	logic                     w_we, s_we, g_we;
	logic [31:0]              w_wdata;
	logic [AW-1:0]            g_wdata;

	logic                     div_start, div_done;
	logic [AW-1:0]            div_dividend, div_quot;
	logic [DVW-1:0]           div_divisor;

	logic signed [AW:0]       gsum, lsum_s, nw_s;
	logic [AW:0]              lsum;
	logic [AW-1:0]            gabs, gsel;
	logic signed [48:0]       step;
	logic [31:0]              pred_c, mean_c;

	assign q_pop = state_q == S_IDLE && q_valid;

	always_comb begin
		unique case (state_q)
			S_IDLE:               rd_addr = q_idx;
			S_LOSS, S_LDIV:       rd_addr = '0;
			S_GRD_ADD, S_UPD_WR:  rd_addr = j_q + IW'(1);
			default:              rd_addr = j_q;
		endcase
	end

	assign s_we    = q_pop;
	assign g_we    = state_q == S_GRD_ADD;
	assign w_we    = state_q == S_UPD_WR;
	assign gsum    = (AW+1)'(gcur_q) + (AW+1)'(prod_s1 >>> lrgd_pkg::FRAC_BITS);
	assign g_wdata = lrgd_pkg::sat64(gsum);
	assign step    = $signed({1'b0, rate}) * $signed(mean_q);
	assign nw_s    = (AW+1)'($signed(wcur_q)) - (AW+1)'(step >>> lrgd_pkg::FRAC_BITS);
	assign w_wdata = lrgd_pkg::sat32(nw_s);
	assign lsum    = {1'b0, loss_q} + (AW+1)'(prod_s1[AW-1:lrgd_pkg::FRAC_BITS]);
	assign lsum_s  = (AW+1)'(dot_q);
	assign pred_c  = lrgd_pkg::sat32(lsum_s);
	assign gsel    = gv_s1 ? g_rdata : '0;
	assign gabs    = gsel[AW-1] ? AW'(0) - gsel : gsel;

	always_comb begin
		if (!neg_q)
			mean_c = (|div_quot[AW-1:31]) ? 32'h7fffffff : div_quot[31:0];
		else if ((|div_quot[AW-1:32]) || (div_quot[31] && (|div_quot[30:0])))
			mean_c = 32'h80000000;
		else
			mean_c = 32'd0 - div_quot[31:0];
	end

	assign div_start    = (state_q == S_END && it_q.batch_end) || state_q == S_UPD_RD;
	assign div_dividend = state_q == S_END ? loss_q : gabs;
	assign div_divisor  = state_q == S_END ? {cnt_q, 1'b0} : {1'b0, cnt_q};

	lrgd_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_wram (
		.clk(clk), .we(w_we), .waddr(j_q), .wdata(w_wdata),
		.raddr(rd_addr), .rdata(w_rdata)
	);

	lrgd_ram #(.WIDTH(32), .DEPTH(MAX_FEATURES)) u_sram (
		.clk(clk), .we(s_we), .waddr(q_idx), .wdata(q_item.feature),
		.raddr(rd_addr), .rdata(s_rdata)
	);

	lrgd_ram #(.WIDTH(AW), .DEPTH(MAX_FEATURES)) u_gram (
		.clk(clk), .we(g_we), .waddr(j_q), .wdata(g_wdata),
		.raddr(rd_addr), .rdata(g_rdata)
	);

	lrgd_div #(.DVW(DVW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			dot_q     <= '0;
			loss_q    <= '0;
			cnt_q     <= '0;
			wvalid_q  <= '0;
			gvalid_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			wv_s1 <= wvalid_q[rd_addr];
			gv_s1 <= gvalid_q[rd_addr];
			if (out_valid && out_ready && state_q != S_OUT)
				out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						it_q    <= q_item;
						idx_q   <= q_idx;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					prod_s1 <= $signed(it_q.feature) * $signed(wv_s1 ? w_rdata : 32'd0);
					state_q <= S_DOT;
				end
				S_DOT: begin
					dot_q   <= dot_q + (prod_s1 >>> lrgd_pkg::FRAC_BITS);
					state_q <= it_q.last ? S_ERR : S_IDLE;
				end
				S_ERR: begin
					pred_q  <= pred_c;
					err_q   <= lrgd_pkg::sat32((AW+1)'($signed(pred_c))
						- (AW+1)'($signed(it_q.target)));
					state_q <= S_SQ;
				end
				S_SQ: begin
					prod_s1 <= $signed(err_q) * $signed(err_q);
					state_q <= S_LOSS;
				end
				S_LOSS: begin
					loss_q  <= lsum[AW] ? '1 : lsum[AW-1:0];
					if (cnt_q != '1)
						cnt_q <= cnt_q + COUNT_BITS'(1);
					dot_q   <= '0;
					j_q     <= '0;
					state_q <= it_q.func ? S_GRD_MUL : S_END;
				end
				S_GRD_MUL: begin
					prod_s1 <= $signed(err_q) * $signed(s_rdata);
					gcur_q  <= gv_s1 ? g_rdata : '0;
					state_q <= S_GRD_ADD;
				end
				S_GRD_ADD: begin
					gvalid_q[j_q] <= 1'b1;
					j_q           <= j_q + IW'(1);
					state_q       <= j_q == idx_q ? S_END : S_GRD_MUL;
				end
				S_END: begin
					if (it_q.batch_end) begin
						state_q <= S_LDIV;
					end else begin
						loss_out_q <= '0;
						upd_q      <= 1'b0;
						state_q    <= S_OUT;
					end
				end
				S_LDIV: begin
					if (div_done) begin
						loss_out_q <= (|div_quot[AW-1:32]) ? '1 : div_quot[31:0];
						upd_q      <= it_q.func;
						j_q        <= '0;
						state_q    <= it_q.func ? S_UPD_RD : S_CLR;
					end
				end
				S_UPD_RD: begin
					neg_q   <= gsel[AW-1];
					wcur_q  <= wv_s1 ? w_rdata : '0;
					state_q <= S_UPD_DIV;
				end
				S_UPD_DIV: begin
					if (div_done) begin
						mean_q  <= mean_c;
						state_q <= S_UPD_MUL;
					end
				end
				S_UPD_MUL: begin
					state_q <= S_UPD_WR;
				end
				S_UPD_WR: begin
					wvalid_q[j_q] <= 1'b1;
					j_q           <= j_q + IW'(1);
					state_q       <= (NW'(j_q) + NW'(1)) == n_eff ? S_CLR : S_UPD_RD;
				end
				S_CLR: begin
					gvalid_q <= '0;
					loss_q   <= '0;
					cnt_q    <= '0;
					state_q  <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_res   <= '{prediction: pred_q, batch_loss: loss_out_q,
							loss_valid: it_q.batch_end, weights_updated: upd_q};
						out_valid <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/linear_regression_gd_trainer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_core
// Q16.16 linear-regression trainer with mini-batch gradient descent.
//
//   port group   dir  contents
//   s_*          in   one feature request per transfer, sample target, batch end
//   m_*          out  prediction and batch loss per finished sample
//   APB          in   feature_count at 0x0, learning_rate at 0x4
//
// A feature that does not end a sample passes the idle, fetch and dot states.
// A sample end adds the error, square, loss, end and output states, plus a
// gradient multiply and add per feature in train mode. A batch end adds the
// loss divide, and in train mode a per-weight divide, in the shared divider.
// Reset clears weights and gradient sums through per-entry valid flags.
// The two-entry queue accepts requests until full while the sequencer or output stalls.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer_core #(
	parameter int MAX_FEATURES = lrgd_pkg::MAX_FEATURES_DEF,
	parameter int COUNT_BITS   = lrgd_pkg::COUNT_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [63:0] s_tdata,   // feature_value, target_value
	input  wire         s_tlast,
	input  wire         s_tuser,   // func
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [63:0] m_tdata,   // prediction, batch_loss
	output logic        m_tlast,
	output logic        m_tuser,   // weights_updated
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IW = MAX_FEATURES > 1 ? $clog2(MAX_FEATURES) : 1;
	localparam int NW = $clog2(MAX_FEATURES + 1);

	logic [lrgd_pkg::FC_W-1:0] fc_q;
	logic [lrgd_pkg::LR_W-1:0] lr_q;
	logic [NW-1:0]             n_eff;
	logic                      q_valid, q_pop;
	lrgd_pkg::lrgd_item_t      q_item;
	logic [IW-1:0]             q_idx;
	lrgd_pkg::lrgd_result_t    res;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= lrgd_pkg::FC_RESET;
			lr_q <= lrgd_pkg::LR_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (paddr[2] == lrgd_pkg::REG_FEATURE_COUNT)
				fc_q <= pwdata[lrgd_pkg::FC_W-1:0];
			else
				lr_q <= pwdata[lrgd_pkg::LR_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			lrgd_pkg::REG_FEATURE_COUNT: prdata = 32'(fc_q);
			lrgd_pkg::REG_LEARNING_RATE: prdata = 32'(lr_q);
			default:                     prdata = '0;
		endcase
	end

	always_comb begin
		if (fc_q == '0)
			n_eff = NW'(1);
		else if (32'(fc_q) > 32'(MAX_FEATURES))
			n_eff = NW'(MAX_FEATURES);
		else
			n_eff = NW'(fc_q);
	end

	lrgd_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.s_tdata(s_tdata), .s_tlast(s_tlast), .s_tuser(s_tuser), .n_eff(n_eff),
		.q_valid(q_valid), .q_item(q_item), .q_idx(q_idx), .q_pop(q_pop)
	);

	lrgd_back #(.MAX_FEATURES(MAX_FEATURES), .COUNT_BITS(COUNT_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_item(q_item),
		.q_idx(q_idx), .q_pop(q_pop), .n_eff(n_eff), .rate(lr_q),
		.out_valid(m_tvalid), .out_ready(m_tready), .out_res(res)
	);

	assign m_tdata = {res.batch_loss, res.prediction};
	assign m_tlast = res.loss_valid;
	assign m_tuser = res.weights_updated;

endmodule
`default_nettype wire

// ----- tb/sv/linear_regression_gd_trainer_core_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// linear_regression_gd_trainer_core_test
// Streams Q16.16 feature requests into the trainer, predicts each finished
// sample's prediction and each batch's loss and weight update, and checks the
// result stream field by field against that prediction under random stalls.
// ----------------------------------------------------------------------------
module linear_regression_gd_trainer_core_test;

	localparam int NFEAT     = 64;
	localparam int CNT_MAX   = 65535;
	localparam int LIMIT     = 2000000;

	typedef struct {
		logic        func;
		logic [31:0] feature;
		logic [31:0] target;
		logic        batch_end;
	} request_t;

	typedef struct {
		logic [31:0] prediction;
		logic [31:0] batch_loss;
		logic        loss_valid;
		logic        weights_updated;
	} sample_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	wire         s_tready;
	logic [63:0] s_tdata;   // feature_value, target_value
	logic        s_tlast;   // last_of_batch
	logic        s_tuser;   // func
	wire         m_tvalid;
	logic        m_tready;
	wire  [63:0] m_tdata;   // prediction, batch_loss
	wire         m_tlast;   // loss_valid
	wire         m_tuser;   // weights_updated
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;

	linear_regression_gd_trainer_core u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tlast(s_tlast), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	request_t       pending_requests[$];
	sample_result_t expected_results[$];
	request_t       cur_req;
	int             mismatches;
	int             cycles;
	bit             calm;

	// trainer state
	longint          weight_q[NFEAT];
	longint          grad_sum[NFEAT];
	longint          sample_buf[NFEAT];
	int unsigned     feat_idx;
	longint          dot_acc;
	longint unsigned loss_acc;
	int unsigned     sample_cnt;
	logic [6:0]      feat_count;
	logic [15:0]     step_rate;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint clamp_s32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint add_sat64(input longint a, input longint b);
		if (b > 0 && a > 64'sh7fffffffffffffff - b) return 64'sh7fffffffffffffff;
		if (b < 0 && a < 64'sh8000000000000000 - b) return 64'sh8000000000000000;
		return a + b;
	endfunction

	task automatic reset_trainer();
		for (int j = 0; j < NFEAT; j++) begin
			weight_q[j] = 0;
			grad_sum[j] = 0;
			sample_buf[j] = 0;
		end
		feat_idx = 0;
		dot_acc = 0;
		loss_acc = 0;
		sample_cnt = 0;
		feat_count = lrgd_pkg::FC_RESET;
		step_rate = lrgd_pkg::LR_RESET;
	endtask

	task automatic train_step(input request_t r);
		int unsigned     n;
		int unsigned     idx;
		longint          x;
		longint          pred;
		longint          err;
		longint          mean;
		longint unsigned sq;
		longint unsigned mag;
		sample_result_t  res;
		n = (feat_count == 0) ? 1 : (feat_count > NFEAT) ? NFEAT : feat_count;
		idx = (feat_idx >= NFEAT) ? NFEAT - 1 : feat_idx;
		x = longint'(signed'(r.feature));
		sample_buf[idx] = x;
		dot_acc += (x * weight_q[idx]) >>> 16;
		if (idx + 1 < n) begin
			feat_idx = idx + 1;
			return;
		end
		pred = clamp_s32(dot_acc);
		err = clamp_s32(pred - longint'(signed'(r.target)));
		sq = longint'(unsigned'(err * err)) >> 16;
		loss_acc = (loss_acc > 64'hffffffffffffffff - sq) ? 64'hffffffffffffffff
			: loss_acc + sq;
		if (sample_cnt < CNT_MAX) sample_cnt++;
		if (r.func)
			for (int j = 0; j <= idx; j++)
				grad_sum[j] = add_sat64(grad_sum[j], (err * sample_buf[j]) >>> 16);
		res.prediction = pred[31:0];
		res.batch_loss = 0;
		res.loss_valid = r.batch_end;
		res.weights_updated = 1'b0;
		if (r.batch_end) begin
			sq = loss_acc / (2 * longint'(sample_cnt));
			res.batch_loss = (sq > 64'hffffffff) ? 32'hffffffff : sq[31:0];
			if (r.func) begin
				for (int j = 0; j < n; j++) begin
					if (grad_sum[j] >= 0) begin
						mean = grad_sum[j] / longint'(sample_cnt);
					end else begin
						mag = 64'd0 - longint'(unsigned'(grad_sum[j]));
						mag = mag / sample_cnt;
						mean = (mag > 64'd2147483648) ? -64'sd2147483648 : -longint'(mag);
					end
					mean = clamp_s32(mean);
					weight_q[j] = clamp_s32(weight_q[j] -
						((longint'(step_rate) * mean) >>> 16));
				end
				res.weights_updated = 1'b1;
			end
			for (int j = 0; j < NFEAT; j++) grad_sum[j] = 0;
			loss_acc = 0;
			sample_cnt = 0;
		end
		feat_idx = 0;
		dot_acc = 0;
		expected_results.insert(expected_results.size(), res);
	endtask

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		mismatches++;
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin : drv
		int gap;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tlast <= 1'b0;
			s_tuser <= 1'b0;
			gap = 0;
		end else begin
			if (s_tvalid && s_tready) train_step(cur_req);
			if (!s_tvalid || s_tready) begin
				if (gap > 0) begin
					gap--;
					s_tvalid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					cur_req = pending_requests.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {cur_req.target, cur_req.feature};
					s_tlast <= cur_req.batch_end;
					s_tuser <= cur_req.func;
					gap = calm ? 0 : $urandom_range(0, 10);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin : mon
		int stall;
		sample_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					report("unexpected result", m_tdata, 0);
				end else begin
					want = expected_results.pop_front();
					if (m_tdata[31:0] !== want.prediction)
						report("prediction", m_tdata[31:0], want.prediction);
					if (m_tdata[63:32] !== want.batch_loss)
						report("batch_loss", m_tdata[63:32], want.batch_loss);
					if (m_tlast !== want.loss_valid)
						report("loss_valid", m_tlast, want.loss_valid);
					if (m_tuser !== want.weights_updated)
						report("weights_updated", m_tuser, want.weights_updated);
				end
				stall = calm ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("** linear_regression_gd_trainer_core: FAILED **");
			$finish;
		end
	end

	task automatic reg_write(input logic index, input logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (index == lrgd_pkg::REG_FEATURE_COUNT) feat_count = value[6:0];
		else step_rate = value[15:0];
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain();
		while (pending_requests.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($urandom_range(0, 32'h3ffff)) - 32'h1ffff;
		endcase
	endfunction

	task automatic push(input logic f, input logic [31:0] x, input logic [31:0] t,
			input logic e);
		request_t r;
		r.func = f;
		r.feature = x;
		r.target = t;
		r.batch_end = e;
		pending_requests.insert(pending_requests.size(), r);
	endtask

	// one well-formed batch; non-final features carry random func/target/end
	task automatic push_batch(input int features, input int samples, input int mode);
		logic f;
		for (int s = 0; s < samples; s++) begin
			f = (mode == 2) ? 1'($urandom) : 1'(mode);
			for (int k = 0; k < features; k++)
				if (k == features - 1)
					push(f, pick_value(), pick_value(), s == samples - 1);
				else
					push(1'($urandom), pick_value(), $urandom, 1'($urandom));
		end
	endtask

	initial begin
		int fc;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		cycles = 0;
		calm = 1'b0;
		reset_trainer();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// single-feature extremes at reset settings
		push(1'b0, 32'h7fffffff, 32'h80000000, 1'b1);
		push(1'b1, 32'h80000000, 32'h7fffffff, 1'b0);
		push(1'b1, 32'h00010000, 32'h7fffffff, 1'b1);
		push(1'b1, 32'hffffffff, 32'h00000000, 1'b0);
		push(1'b0, 32'h7fffffff, 32'h80000000, 1'b1);
		push(1'b1, 32'h7fffffff, 32'h80000000, 1'b1);
		push(1'b0, 32'h7fffffff, 32'h00000000, 1'b1);
		drain();

		reg_write(lrgd_pkg::REG_FEATURE_COUNT, 3);
		reg_write(lrgd_pkg::REG_LEARNING_RATE, 65535);
		push_batch(3, 3, 1);
		push_batch(3, 2, 2);
		drain();

		// zero acts as one, oversize acts as the full width
		reg_write(lrgd_pkg::REG_FEATURE_COUNT, 0);
		reg_write(lrgd_pkg::REG_LEARNING_RATE, 0);
		push_batch(1, 2, 1);
		drain();
		reg_write(lrgd_pkg::REG_FEATURE_COUNT, 127);
		reg_write(lrgd_pkg::REG_LEARNING_RATE, 40000);
		push_batch(64, 2, 1);
		drain();

		// lower the count mid-sample
		reg_write(lrgd_pkg::REG_FEATURE_COUNT, 5);
		push_batch(5, 1, 1);
		push(1'b1, pick_value(), pick_value(), 1'b0);
		push(1'b1, pick_value(), pick_value(), 1'b0);
		push(1'b1, pick_value(), pick_value(), 1'b0);
		drain();
		reg_write(lrgd_pkg::REG_FEATURE_COUNT, 2);
		push(1'b1, pick_value(), pick_value(), 1'b1);
		push_batch(2, 2, 1);
		drain();

		// random phases
		for (int p = 0; p < 12; p++) begin
			fc = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
			reg_write(lrgd_pkg::REG_FEATURE_COUNT, fc);
			reg_write(lrgd_pkg::REG_LEARNING_RATE, ($urandom_range(0, 3) == 0)
				? $urandom_range(0, 65535) : $urandom_range(0, 2000));
			calm = ($urandom_range(0, 4) == 0);
			for (int b = 0; b < 4; b++) begin
				if ($urandom_range(0, 5) == 0)
					push(1'($urandom), $urandom, $urandom, 1'($urandom));
				else
					push_batch(fc, (fc > 8) ? 1 : $urandom_range(1, 6), $urandom_range(0, 2));
			end
			drain();
		end

		if (mismatches == 0)
			$display("** linear_regression_gd_trainer_core: PASSED **");
		else
			$display("** linear_regression_gd_trainer_core: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/lrgd_pkg.sv
rtl/lrgd_ram.sv
rtl/lrgd_div.sv
rtl/lrgd_front.sv
rtl/lrgd_back.sv
rtl/linear_regression_gd_trainer_core.sv
tb/sv/linear_regression_gd_trainer_core_test.sv
